### rtl/core/rlw_pkg.sv
// Shared types and constants for the radial lens distortion warp.
// Field widths, configuration register codes and saturation limits.
// No dependencies.
package rlw_pkg;

  localparam int IN_W        = 17;
  localparam int REG_W       = 20;
  localparam int OUT_W       = 20;
  localparam int SCALE_W     = REG_W + 1;
  localparam int WIDE_W      = 32;
  localparam int CFG_INDEX_W = 3;

  localparam longint WIDE_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint OUT_MAX  = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
  localparam longint OUT_MIN  = -OUT_MAX - 64'sd1;

  localparam logic signed [REG_W-1:0] BASE_SCALE_RESET = 20'sd65536;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_RADIAL_FIRST  = 3'd0,
    CFG_RADIAL_SECOND = 3'd1,
    CFG_BASE_SCALE    = 3'd2,
    CFG_BLUE_OFFSET   = 3'd3,
    CFG_GREEN_OFFSET  = 3'd4,
    CFG_RED_OFFSET    = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic mul_en;
    logic rnd_en;
    logic sat_en;
  } lane_en_t;

endpackage

### rtl/core/rlw_lane.sv
// One colour lane: scales a warped coordinate and maps it back to [0,1] space.
// Three pipeline stages: multiply, round and saturate, final half and clamp.
// Depends on rlw_pkg.
module rlw_lane #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                                   clk,
  input  rlw_pkg::lane_en_t                      en,
  input  logic signed [rlw_pkg::WIDE_W-1:0]      coord,
  input  logic signed [rlw_pkg::SCALE_W-1:0]     scale,
  output logic signed [rlw_pkg::OUT_W-1:0]       result
);

  localparam int     F    = FRACTION_BITS;
  localparam longint ONE  = 64'sd1 <<< F;
  localparam longint HALF = 64'sd1 <<< (F - 1);
  localparam int     PW_W = rlw_pkg::WIDE_W + rlw_pkg::SCALE_W;
  localparam int     WF_W = PW_W + 1 - F;

  logic signed [PW_W-1:0]            prod;
  logic signed [PW_W:0]              prod_rnd;
  logic signed [WF_W-1:0]            w_full;
  longint                            w_wide;
  logic signed [rlw_pkg::WIDE_W-1:0] w;
  longint                            o_wide;

  always_comb begin
    prod_rnd = $signed({prod[PW_W-1], prod}) + (PW_W + 1)'(HALF);
    w_full   = prod_rnd[PW_W:F];
    w_wide   = 64'(w_full);
    o_wide   = (64'(w) + ONE + 64'sd1) >>> 1;
  end

  always_ff @(posedge clk) begin
    if (en.mul_en) begin
      prod <= coord * scale;
    end
    if (en.rnd_en) begin
      if (w_wide > rlw_pkg::WIDE_MAX) begin
        w <= rlw_pkg::WIDE_W'(rlw_pkg::WIDE_MAX);
      end else if (w_wide < -rlw_pkg::WIDE_MAX) begin
        w <= rlw_pkg::WIDE_W'(-rlw_pkg::WIDE_MAX);
      end else begin
        w <= rlw_pkg::WIDE_W'(w_wide);
      end
    end
    if (en.sat_en) begin
      if (o_wide > rlw_pkg::OUT_MAX) begin
        result <= rlw_pkg::OUT_W'(rlw_pkg::OUT_MAX);
      end else if (o_wide < rlw_pkg::OUT_MIN) begin
        result <= rlw_pkg::OUT_W'(rlw_pkg::OUT_MIN);
      end else begin
        result <= rlw_pkg::OUT_W'(o_wide);
      end
    end
  end

endmodule

### rtl/core/radial_lens_distortion_warp.sv
// Top level of the radial lens distortion warp with per-colour scale.
// Holds the configuration registers, the radial factor pipeline and six lanes.
// Depends on rlw_pkg and rlw_lane.
//
// Usage:
//   Write the six Q4.16 registers through cfg_write/cfg_index/cfg_data while
//   the block is idle; indexes 6 and 7 are ignored. Coordinates enter as a
//   word on in_valid/in_ready (u_coord, v_coord, unsigned, 16 fraction bits).
//   Each word yields one result word on out_valid/out_ready carrying the
//   blue, green and red u/v pairs, signed and saturated to 20 bits.
//   The datapath is 11 register stages with a valid bit in each; out_valid
//   is the valid bit of the last stage. Throughput is one word per cycle
//   unless the receiver stalls, set by the fully pipelined multipliers.
//   When the receiver stalls, the output stage holds and each stage advances
//   only into an empty or moving successor, so empty stages still fill and
//   in_ready drops only once every stage holds a word.
//   Reset (rst, synchronous) empties the pipeline and loads register defaults:
//   base scale 1.0, all coefficients and offsets zero.
module radial_lens_distortion_warp #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_write,
  input  logic [rlw_pkg::CFG_INDEX_W-1:0]         cfg_index,
  input  logic [rlw_pkg::REG_W-1:0]               cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [rlw_pkg::IN_W-1:0]                u_coord,
  input  logic [rlw_pkg::IN_W-1:0]                v_coord,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [rlw_pkg::OUT_W-1:0]        blue_u,
  output logic signed [rlw_pkg::OUT_W-1:0]        blue_v,
  output logic signed [rlw_pkg::OUT_W-1:0]        green_u,
  output logic signed [rlw_pkg::OUT_W-1:0]        green_v,
  output logic signed [rlw_pkg::OUT_W-1:0]        red_u,
  output logic signed [rlw_pkg::OUT_W-1:0]        red_v
);

  localparam int     F      = FRACTION_BITS;
  localparam int     NSTG   = 11;
  localparam longint ONE    = 64'sd1 <<< F;
  localparam longint HALF   = 64'sd1 <<< (F - 1);
  localparam int     IN_W   = rlw_pkg::IN_W;
  localparam int     REG_W  = rlw_pkg::REG_W;
  localparam int     WIDE_W = rlw_pkg::WIDE_W;
  localparam int     DU_W   = ((F > IN_W) ? F : IN_W) + 1;
  localparam int     SQ_W   = 2 * DU_W;
  localparam int     R2_W   = SQ_W - F;
  localparam int     R2SQ_W = 2 * R2_W;
  localparam int     R4F_W  = R2SQ_W + 1 - F;
  localparam int     R4_W   = WIDE_W - 1;
  localparam int     KR2_W  = REG_W + R2_W + 1;
  localparam int     KR2S_W = KR2_W + 1 - F;
  localparam int     KR4_W  = REG_W + WIDE_W;
  localparam int     KR4S_W = KR4_W + 1 - F;
  localparam int     CU_W   = (((F + 1) > (IN_W + 1)) ? (F + 1) : (IN_W + 1)) + 1;
  localparam int     PU_W   = CU_W + WIDE_W;
  localparam int     TF_W   = PU_W + 1 - F;

  // configuration
  logic signed [REG_W-1:0] k0, k1, base_scale, blue_off, green_off, red_off;
  logic signed [rlw_pkg::SCALE_W-1:0] blue_scale, green_scale, red_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      k0         <= '0;
      k1         <= '0;
      base_scale <= rlw_pkg::BASE_SCALE_RESET;
      blue_off   <= '0;
      green_off  <= '0;
      red_off    <= '0;
    end else if (cfg_write) begin
      unique case (rlw_pkg::cfg_index_t'(cfg_index))
        rlw_pkg::CFG_RADIAL_FIRST:  k0         <= $signed(cfg_data);
        rlw_pkg::CFG_RADIAL_SECOND: k1         <= $signed(cfg_data);
        rlw_pkg::CFG_BASE_SCALE:    base_scale <= $signed(cfg_data);
        rlw_pkg::CFG_BLUE_OFFSET:   blue_off   <= $signed(cfg_data);
        rlw_pkg::CFG_GREEN_OFFSET:  green_off  <= $signed(cfg_data);
        rlw_pkg::CFG_RED_OFFSET:    red_off    <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  assign blue_scale  = $signed({base_scale[REG_W-1], base_scale})
                     + $signed({blue_off[REG_W-1], blue_off});
  assign green_scale = $signed({base_scale[REG_W-1], base_scale})
                     + $signed({green_off[REG_W-1], green_off});
  assign red_scale   = $signed({base_scale[REG_W-1], base_scale})
                     + $signed({red_off[REG_W-1], red_off});

  // stage control
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;

  always_comb begin
    for (int i = 0; i < NSTG; i++) begin
      en[i] = out_ready || ((vld | NSTG'((1 << i) - 1)) != '1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NSTG-1];

  // datapath
  logic signed [DU_W-1:0]    du, dv;
  logic signed [CU_W-1:0]    cu_in, cv_in;
  logic signed [SQ_W-1:0]    sq_sum, r2_rnd;
  logic signed [CU_W-1:0]    cu0, cv0, cu1, cv1, cu2, cv2, cu3, cv3, cu4, cv4, cu5, cv5;
  logic [R2_W-1:0]           r2;
  logic [R2SQ_W-1:0]         r2sq;
  logic [R2SQ_W:0]           r2sq_rnd;
  logic [R4F_W-1:0]          r4_full;
  logic [R4_W-1:0]           r4;
  logic signed [KR2_W-1:0]   kr2;
  logic signed [KR2_W:0]     kr2_rnd;
  logic signed [KR2S_W-1:0]  kr2s, kr2s4;
  logic signed [KR4_W-1:0]   kr4;
  logic signed [KR4_W:0]     kr4_rnd;
  logic signed [KR4S_W-1:0]  kr4s;
  longint                    d_wide;
  logic signed [WIDE_W-1:0]  d;
  logic signed [PU_W-1:0]    pu, pv;
  logic signed [PU_W:0]      pu_rnd, pv_rnd;
  logic signed [TF_W-1:0]    tu_full, tv_full;
  longint                    tu_wide, tv_wide;
  logic signed [WIDE_W-1:0]  tu, tv;

  always_comb begin
    du       = $signed(DU_W'(u_coord)) - DU_W'(HALF);
    dv       = $signed(DU_W'(v_coord)) - DU_W'(HALF);
    cu_in    = $signed(CU_W'({u_coord, 1'b0})) - CU_W'(ONE);
    cv_in    = $signed(CU_W'({v_coord, 1'b0})) - CU_W'(ONE);
    r2_rnd   = sq_sum + SQ_W'(HALF);
    r2sq_rnd = {1'b0, r2sq} + (R2SQ_W + 1)'(HALF);
    r4_full  = r2sq_rnd[R2SQ_W:F];
    kr2_rnd  = $signed({kr2[KR2_W-1], kr2}) + (KR2_W + 1)'(HALF);
    kr4_rnd  = $signed({kr4[KR4_W-1], kr4}) + (KR4_W + 1)'(HALF);
    kr4s     = kr4_rnd[KR4_W:F];
    d_wide   = ONE + 64'(kr2s4) + 64'(kr4s);
    pu_rnd   = $signed({pu[PU_W-1], pu}) + (PU_W + 1)'(HALF);
    pv_rnd   = $signed({pv[PU_W-1], pv}) + (PU_W + 1)'(HALF);
    tu_full  = pu_rnd[PU_W:F];
    tv_full  = pv_rnd[PU_W:F];
    tu_wide  = 64'(tu_full);
    tv_wide  = 64'(tv_full);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sq_sum <= du * du + dv * dv;
      cu0    <= cu_in;
      cv0    <= cv_in;
    end
    if (en[1]) begin
      r2  <= r2_rnd[SQ_W-1:F];
      cu1 <= cu0;
      cv1 <= cv0;
    end
    if (en[2]) begin
      r2sq <= r2 * r2;
      kr2  <= k0 * $signed({1'b0, r2});
      cu2  <= cu1;
      cv2  <= cv1;
    end
    if (en[3]) begin
      if (64'(r4_full) > 64'(rlw_pkg::WIDE_MAX)) begin
        r4 <= R4_W'(rlw_pkg::WIDE_MAX);
      end else begin
        r4 <= R4_W'(r4_full);
      end
      kr2s <= kr2_rnd[KR2_W:F];
      cu3  <= cu2;
      cv3  <= cv2;
    end
    if (en[4]) begin
      kr4   <= k1 * $signed({1'b0, r4});
      kr2s4 <= kr2s;
      cu4   <= cu3;
      cv4   <= cv3;
    end
    if (en[5]) begin
      if (d_wide > rlw_pkg::WIDE_MAX) begin
        d <= WIDE_W'(rlw_pkg::WIDE_MAX);
      end else if (d_wide < -rlw_pkg::WIDE_MAX) begin
        d <= WIDE_W'(-rlw_pkg::WIDE_MAX);
      end else begin
        d <= WIDE_W'(d_wide);
      end
      cu5 <= cu4;
      cv5 <= cv4;
    end
    if (en[6]) begin
      pu <= cu5 * d;
      pv <= cv5 * d;
    end
    if (en[7]) begin
      if (tu_wide > rlw_pkg::WIDE_MAX) begin
        tu <= WIDE_W'(rlw_pkg::WIDE_MAX);
      end else if (tu_wide < -rlw_pkg::WIDE_MAX) begin
        tu <= WIDE_W'(-rlw_pkg::WIDE_MAX);
      end else begin
        tu <= WIDE_W'(tu_wide);
      end
      if (tv_wide > rlw_pkg::WIDE_MAX) begin
        tv <= WIDE_W'(rlw_pkg::WIDE_MAX);
      end else if (tv_wide < -rlw_pkg::WIDE_MAX) begin
        tv <= WIDE_W'(-rlw_pkg::WIDE_MAX);
      end else begin
        tv <= WIDE_W'(tv_wide);
      end
    end
  end

  rlw_pkg::lane_en_t lane_en;

  assign lane_en = '{mul_en: en[8], rnd_en: en[9], sat_en: en[10]};

  rlw_lane #(.FRACTION_BITS(FRACTION_BITS)) u_blue_u (
    .clk(clk), .en(lane_en), .coord(tu), .scale(blue_scale), .result(blue_u)
  );
  rlw_lane #(.FRACTION_BITS(FRACTION_BITS)) u_blue_v (
    .clk(clk), .en(lane_en), .coord(tv), .scale(blue_scale), .result(blue_v)
  );
  rlw_lane #(.FRACTION_BITS(FRACTION_BITS)) u_green_u (
    .clk(clk), .en(lane_en), .coord(tu), .scale(green_scale), .result(green_u)
  );
  rlw_lane #(.FRACTION_BITS(FRACTION_BITS)) u_green_v (
    .clk(clk), .en(lane_en), .coord(tv), .scale(green_scale), .result(green_v)
  );
  rlw_lane #(.FRACTION_BITS(FRACTION_BITS)) u_red_u (
    .clk(clk), .en(lane_en), .coord(tu), .scale(red_scale), .result(red_u)
  );
  rlw_lane #(.FRACTION_BITS(FRACTION_BITS)) u_red_v (
    .clk(clk), .en(lane_en), .coord(tv), .scale(red_scale), .result(red_v)
  );

endmodule
